>>> rtl/plc_pkg.sv
`timescale 1ns / 1ps

package plc_pkg;

	// Field widths fixed by the command and result formats
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned ITEM_W  = 32;
	localparam int unsigned COUNT_W = 7;

	typedef logic [CMD_W-1:0]          cmd_t;
	typedef logic [POS_W-1:0]          pos_t;
	typedef logic signed [ITEM_W-1:0]  item_t;
	typedef logic [COUNT_W-1:0]        count_t;

	// Command codes
	localparam cmd_t CMD_INSERT  = 3'd0;
	localparam cmd_t CMD_DELETE  = 3'd1;
	localparam cmd_t CMD_GET     = 3'd2;
	localparam cmd_t CMD_REPLACE = 3'd3;
	localparam cmd_t CMD_CLEAR   = 3'd4;

	// Per-cycle action broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL,
		OP_PUT
	} cell_op_t;

endpackage

>>> rtl/plc_cmd_if.sv
`timescale 1ns / 1ps

interface plc_cmd_if;
	import plc_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  cmd;
	pos_t  position;
	item_t item_in;

	modport source (output valid, output cmd, output position, output item_in, input ready);
	modport sink   (input valid, input cmd, input position, input item_in, output ready);
endinterface

>>> rtl/plc_res_if.sv
`timescale 1ns / 1ps

interface plc_res_if;
	import plc_pkg::*;

	logic   valid;
	logic   ready;
	logic   ok;
	item_t  item_out;
	count_t count;
	logic   is_full;
	logic   is_empty;

	modport source (output valid, output ok, output item_out, output count,
		output is_full, output is_empty, input ready);
	modport sink   (input valid, input ok, input item_out, input count,
		input is_full, input is_empty, output ready);
endinterface

>>> rtl/plc_cell.sv
`timescale 1ns / 1ps

// One list slot. Past the position it takes its left neighbor on insert;
// at/past it, its right one on delete; at it, new item on insert/replace.
module plc_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  plc_pkg::cell_op_t   op,
	input  plc_pkg::pos_t       pos,
	input  plc_pkg::item_t      item_in,
	input  plc_pkg::item_t      left,
	input  plc_pkg::item_t      right,
	output plc_pkg::item_t      data,
	output plc_pkg::item_t      tap
);
	import plc_pkg::*;

	item_t data_q;
	logic  here;
	logic  above;

	// Position compare against this slot's fixed index
	always_comb begin
		here  = ({{(32-POS_W){1'b0}}, pos} == IDX);
		above = ({{(32-POS_W){1'b0}}, pos} <  IDX);
	end

	// Slot update
	always_ff @(posedge clk) begin
		case (op)
			OP_INS: begin
				if (above)
					data_q <= left;
				else if (here)
					data_q <= item_in;
			end
			OP_DEL: begin
				if (above || here)
					data_q <= right;
			end
			OP_PUT: begin
				if (here)
					data_q <= item_in;
			end
			default: ;
		endcase
	end

	assign data = data_q;
	// Masked read tap, OR-combined at the top
	assign tap  = here ? data_q : '0;
endmodule

>>> rtl/positional_insert_list.sv
`timescale 1ns / 1ps

// Fixed-capacity ordered list of signed 32-bit items held in a row of DEPTH
// cells. Commands: insert (shifts later entries up), delete (shifts them down,
// returns the removed item), get, replace and clear. Each command item gives
// one result item with ok, item_out, count, is_full and is_empty. All cells
// shift together in the accepting cycle, and the result sits in an output
// register, so a new command is taken every cycle while the result side
// keeps up. Rejected commands (bad position, insert when full, unused codes)
// return ok 0 and item_out 0 and change nothing. Clear only resets the
// count. count is reported modulo 128.
module positional_insert_list #(
	parameter int unsigned DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	plc_cmd_if.sink           req,
	plc_res_if.source         rsp
);
	import plc_pkg::*;

	localparam int unsigned UW = $clog2(DEPTH + 1);
	localparam int unsigned CW = (UW > POS_W) ? UW : POS_W;

	logic [UW-1:0] used_q;
	logic [UW-1:0] used_nxt;
	logic          accept;
	logic          out_valid_q;
	logic          ok_q;
	item_t         item_out_q;

	logic [CW-1:0] pos_x;
	logic [CW-1:0] used_x;
	logic          pos_lt_used;
	logic          ok;
	logic          rd_sel;
	cell_op_t      op;
	item_t         rd_data;

	item_t data [DEPTH];
	item_t tap  [DEPTH];

	assign accept    = req.valid && req.ready;
	assign req.ready = !out_valid_q || rsp.ready;

	// Command decode and bounds checks
	always_comb begin
		pos_x       = CW'(req.position);
		used_x      = CW'(used_q);
		pos_lt_used = pos_x < used_x;
		ok          = 1'b0;
		rd_sel      = 1'b0;
		op          = OP_HOLD;
		used_nxt    = used_q;
		unique case (req.cmd)
			CMD_INSERT: begin
				if (pos_x <= used_x && used_q < UW'(DEPTH)) begin
					ok       = 1'b1;
					op       = OP_INS;
					used_nxt = used_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (pos_lt_used) begin
					ok       = 1'b1;
					rd_sel   = 1'b1;
					op       = OP_DEL;
					used_nxt = used_q - 1'b1;
				end
			end
			CMD_GET: begin
				if (pos_lt_used) begin
					ok     = 1'b1;
					rd_sel = 1'b1;
				end
			end
			CMD_REPLACE: begin
				if (pos_lt_used) begin
					ok = 1'b1;
					op = OP_PUT;
				end
			end
			CMD_CLEAR: begin
				ok       = 1'b1;
				used_nxt = '0;
			end
			default: ;
		endcase
		if (!accept)
			op = OP_HOLD;
	end

	// Row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		item_t left_d;
		item_t right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = data[i];
		end else begin : g_mid_r
			assign right_d = data[i+1];
		end
		plc_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.op      (op),
			.pos     (req.position),
			.item_in (req.item_in),
			.left    (left_d),
			.right   (right_d),
			.data    (data[i]),
			.tap     (tap[i])
		);
	end

	// Read: only the addressed cell drives a nonzero tap
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++)
			rd_data = rd_data | tap[i];
	end

	// Count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			item_out_q  <= '0;
		end else begin
			if (accept) begin
				used_q      <= used_nxt;
				out_valid_q <= 1'b1;
				ok_q        <= ok;
				item_out_q  <= rd_sel ? rd_data : '0;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.ok       = ok_q;
	assign rsp.item_out = item_out_q;
	assign rsp.count    = COUNT_W'(used_q);
	assign rsp.is_full  = (used_q == UW'(DEPTH));
	assign rsp.is_empty = (used_q == '0);
endmodule

>>> tb/sv/positional_insert_list_tb.sv
`timescale 1ns / 1ps

module positional_insert_list_tb;
	import plc_pkg::*;

	localparam int unsigned LIST_DEPTH = 64;
	localparam int unsigned POS_MAX = (1 << POS_W) - 1;

	// Codes the block does not implement; they must be rejected
	localparam cmd_t CMD_UNUSED_LO = 3'd5;
	localparam cmd_t CMD_UNUSED_HI = 3'd7;

	typedef enum int {PH_FILL, PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

	typedef struct {
		logic   ok;
		item_t  item;
		count_t count;
		logic   full;
		logic   empty;
	} reply_t;

	// Shadow copy of the list plus the replies it predicts
	class list_mirror;
		item_t  slots [LIST_DEPTH];
		int     used;
		reply_t replies [$];
		int     errors;

		function new();
			used = 0;
			errors = 0;
		endfunction

		task report_mismatch(string msg);
			$display("ERROR %0t ns: %s", $time, msg);
			errors++;
		endtask

		function int pending();
			return replies.size();
		endfunction

		// Apply one accepted command and queue the reply it must produce
		function void take_cmd(cmd_t c, pos_t p, item_t d);
			reply_t r;
			int i;
			r.ok = 1'b0;
			r.item = '0;
			case (c)
				CMD_INSERT: begin
					if (p <= used && used < LIST_DEPTH) begin
						for (i = used; i > p; i--)
							slots[i] = slots[i-1];
						slots[p] = d;
						used++;
						r.ok = 1'b1;
					end
				end
				CMD_DELETE: begin
					if (p < used) begin
						r.item = slots[p];
						for (i = p; i + 1 < used; i++)
							slots[i] = slots[i+1];
						used--;
						r.ok = 1'b1;
					end
				end
				CMD_GET: begin
					if (p < used) begin
						r.item = slots[p];
						r.ok = 1'b1;
					end
				end
				CMD_REPLACE: begin
					if (p < used) begin
						slots[p] = d;
						r.ok = 1'b1;
					end
				end
				CMD_CLEAR: begin
					// contents stay, only the count drops
					used = 0;
					r.ok = 1'b1;
				end
				default: ;
			endcase
			r.count = count_t'(used);
			r.full = (used == LIST_DEPTH);
			r.empty = (used == 0);
			replies.push_back(r);
		endfunction

		task check_reply(logic ok, item_t itm, count_t cnt, logic fl, logic em);
			reply_t e;
			if (replies.size() == 0) begin
				report_mismatch("result item with nothing expected");
				return;
			end
			e = replies.pop_front();
			if (ok !== e.ok)
				report_mismatch($sformatf("ok %b, expected %b", ok, e.ok));
			if (itm !== e.item)
				report_mismatch($sformatf("item_out %0d, expected %0d", itm, e.item));
			if (cnt !== e.count)
				report_mismatch($sformatf("count %0d, expected %0d", cnt, e.count));
			if (fl !== e.full)
				report_mismatch($sformatf("is_full %b, expected %b", fl, e.full));
			if (em !== e.empty)
				report_mismatch($sformatf("is_empty %b, expected %b", em, e.empty));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   steady;

	plc_cmd_if req_ch ();
	plc_res_if rsp_ch ();

	list_mirror lst = new();

	positional_insert_list #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("positional_insert_list test failed");
		$finish;
	end

	// Handshake monitor: predict on command items, check result items
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				lst.take_cmd(req_ch.cmd, req_ch.position, req_ch.item_in);
			if (rsp_ch.valid && rsp_ch.ready)
				lst.check_reply(rsp_ch.ok, rsp_ch.item_out, rsp_ch.count,
					rsp_ch.is_full, rsp_ch.is_empty);
		end
	end

	// Result side: random stall before each result item
	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			n = steady ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			@(negedge clk);
		end
	end

	// Send one command item; entered and left at a falling edge
	task send_cmd(cmd_t c, pos_t p, item_t d);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.cmd = c;
		req_ch.position = p;
		req_ch.item_in = d;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		@(negedge clk);
	endtask

	function item_t pick_item();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return '1;
			default: return item_t'($urandom);
		endcase
	endfunction

	// Mostly in-range positions, sometimes anything the field can hold
	function pos_t pick_pos(int limit);
		if (limit < 0 || $urandom_range(0, 5) == 0)
			return pos_t'($urandom_range(0, POS_MAX));
		return pos_t'($urandom_range(0, limit));
	endfunction

	task random_cmd(phase_t ph);
		int roll;
		cmd_t c;
		roll = $urandom_range(0, 99);
		case (ph)
			PH_FILL:   c = CMD_INSERT;
			PH_GROW:   c = roll < 70 ? CMD_INSERT : roll < 78 ? CMD_DELETE :
				roll < 86 ? CMD_GET : roll < 95 ? CMD_REPLACE :
				roll < 96 ? CMD_CLEAR : CMD_UNUSED_LO;
			PH_SHRINK: c = roll < 15 ? CMD_INSERT : roll < 65 ? CMD_DELETE :
				roll < 80 ? CMD_GET : roll < 92 ? CMD_REPLACE :
				roll < 94 ? CMD_CLEAR : CMD_UNUSED_LO;
			default:   c = roll < 35 ? CMD_INSERT : roll < 55 ? CMD_DELETE :
				roll < 75 ? CMD_GET : roll < 92 ? CMD_REPLACE :
				roll < 96 ? CMD_CLEAR : CMD_UNUSED_LO;
		endcase
		if (c == CMD_UNUSED_LO)
			c = cmd_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		if (c == CMD_INSERT)
			send_cmd(c, pick_pos(lst.used), pick_item());
		else
			send_cmd(c, pick_pos(lst.used - 1), pick_item());
	endtask

	// Main stimulus
	initial begin
		int sent;
		int len;
		int k;
		phase_t ph;

		arst_n = 1'b0;
		steady = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_CLEAR;
		req_ch.position = '0;
		req_ch.item_in = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty list, edges of every field, bad codes
		send_cmd(CMD_CLEAR, 0, 0);
		send_cmd(CMD_GET, 0, 0);
		send_cmd(CMD_DELETE, 0, 0);
		send_cmd(CMD_REPLACE, 0, 32'sh12345678);
		send_cmd(CMD_INSERT, 1, 32'sh11111111);
		send_cmd(CMD_INSERT, 0, 32'sh7fffffff);
		send_cmd(CMD_INSERT, 1, 32'sh80000000);
		send_cmd(CMD_INSERT, 1, '1);
		send_cmd(CMD_INSERT, 0, '0);
		for (k = 0; k <= 4; k++)
			send_cmd(CMD_GET, pos_t'(k), 0);
		send_cmd(CMD_GET, pos_t'(POS_MAX), 0);
		send_cmd(CMD_REPLACE, 2, 32'sh55555555);
		send_cmd(CMD_REPLACE, 4, 32'sh2aaaaaaa);
		send_cmd(CMD_DELETE, 1, 0);
		send_cmd(CMD_DELETE, 3, 0);
		for (k = CMD_UNUSED_LO; k <= CMD_UNUSED_HI; k++)
			send_cmd(cmd_t'(k), pos_t'(POS_MAX), '1);
		send_cmd(CMD_INSERT, pos_t'(POS_MAX), '1);
		send_cmd(CMD_CLEAR, 0, 0);
		send_cmd(CMD_GET, 0, 0);

		// Random phases; the first one fills the list past capacity
		sent = 0;
		ph = PH_FILL;
		while (sent < 1700) begin
			steady = ($urandom_range(0, 3) == 0);
			len = (ph == PH_FILL) ? 90 : $urandom_range(50, 200);
			for (k = 0; k < len && sent < 1700; k++) begin
				random_cmd(ph);
				sent++;
			end
			ph = phase_t'($urandom_range(0, 3));
		end
		req_ch.valid = 1'b0;
		steady = 1'b0;

		// Drain, then give stray results a chance to show up
		while (lst.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (lst.pending() != 0)
			lst.report_mismatch("expected result items never arrived");
		if (lst.errors == 0)
			$display("positional_insert_list test passed");
		else
			$display("positional_insert_list test failed");
		$finish;
	end

endmodule

>>> files.f
rtl/plc_pkg.sv
rtl/plc_cmd_if.sv
rtl/plc_res_if.sv
rtl/plc_cell.sv
rtl/positional_insert_list.sv
tb/sv/positional_insert_list_tb.sv
